/* rtl/sqlb_pkg.sv */
// Shared types and constants for the square/loss bit loss tracker.
// Used by the top level and by the ratio divider; depends on nothing.
package sqlb_pkg;

	// Fixed-point format of the ratio outputs
	localparam int RATIO_FRAC_BITS = 16;
	localparam int RATIO_W         = 24;
	localparam int TOTAL_W         = 32;
	localparam int COUNT_W         = 32;
	// Width of the saturation compare: total<<FRAC against count<<RATIO_W
	localparam int CMP_W           = COUNT_W + RATIO_W;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_HALF_PERIOD = 1'b0;
	localparam logic [15:0] HALF_PERIOD_RESET = 16'd64;

	// Number of directions tracked
	localparam int NUM_DIR = 2;

	typedef struct packed {
		logic        direction;
		logic        q_bit;
		logic        l_bit;
		logic [31:0] packets_seen;
	} pkt_t;

	typedef struct packed {
		logic signed [31:0] square_loss_total;
		logic [31:0]        loss_bit_total;
		logic [23:0]        square_loss_ratio;
		logic [23:0]        loss_bit_ratio;
		logic               half_period_ended;
		logic               zero_packet_count;
	} meas_t;

	// Per-direction state record kept in the state RAM
	typedef struct packed {
		logic        current_square;
		logic [15:0] run_length;
		logic [31:0] half_period_rank;
		logic [31:0] upstream_loss;
		logic [31:0] loss_bit_count;
	} dir_state_t;

	// Request to a ratio divider
	typedef struct packed {
		logic               start;
		logic               force_zero;
		logic [TOTAL_W-1:0] total;
		logic [COUNT_W-1:0] count;
	} div_req_t;

endpackage

/* rtl/sqlb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
module sqlb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/sqlb_div.sv */
// Iterative ratio divider: floor((total << RATIO_FRAC_BITS) / count),
// saturated to RATIO_W bits or forced to zero, one quotient bit per cycle. Uses sqlb_pkg.
module sqlb_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sqlb_pkg::div_req_t            req,
	output logic                          busy,
	output logic [sqlb_pkg::RATIO_W-1:0]  ratio
);
	import sqlb_pkg::*;

	localparam int CNT_W = $clog2(RATIO_W);

	typedef enum logic [1:0] {
		D_IDLE,
		D_PREP,
		D_STEP
	} dstate_t;

	dstate_t            state_q;
	logic [TOTAL_W-1:0] total_q;
	logic [COUNT_W-1:0] count_q;
	logic               force_q;
	logic [COUNT_W-1:0] rem_q;
	logic [RATIO_W-1:0] sh_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [CMP_W-1:0]   num_wide;
	logic [CMP_W-1:0]   lim_wide;
	logic               sat;
	logic [COUNT_W:0]   r2;
	logic               ge;
	logic [COUNT_W-1:0] rem_next;

	// Saturation test: quotient reaches 2^RATIO_W exactly when the
	// shifted total reaches count << RATIO_W
	assign num_wide = CMP_W'(total_q) << RATIO_FRAC_BITS;
	assign lim_wide = CMP_W'(count_q) << RATIO_W;
	assign sat      = num_wide >= lim_wide;

	// Restoring step: shift in the next dividend bit, try a subtract
	assign r2       = {rem_q, sh_q[RATIO_W-1]};
	assign ge       = r2 >= {1'b0, count_q};
	assign rem_next = ge ? COUNT_W'(r2 - {1'b0, count_q}) : r2[COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						state_q <= D_PREP;
					end
				end
				D_PREP: begin
					cnt_q <= '0;
					if (force_q || sat) begin
						state_q <= D_IDLE;
					end else begin
						state_q <= D_STEP;
					end
				end
				D_STEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(RATIO_W - 1)) begin
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && req.start) begin
			total_q <= req.total;
			count_q <= req.count;
			force_q <= req.force_zero;
		end
		if (state_q == D_PREP) begin
			if (force_q) begin
				sh_q <= '0;
			end else if (sat) begin
				sh_q <= '1;
			end else begin
				// high part is below count here, so it fits the remainder
				rem_q <= COUNT_W'(num_wide >> RATIO_W);
				sh_q  <= num_wide[RATIO_W-1:0];
			end
		end else if (state_q == D_STEP) begin
			rem_q <= rem_next;
			sh_q  <= {sh_q[RATIO_W-2:0], ge};
		end
	end

	assign busy  = (state_q != D_IDLE);
	assign ratio = sh_q;

endmodule

/* rtl/square_retransmit_bit_loss_tracker.sv */
// Square-bit / loss-bit loss monitor, top level. One packet is handled at a
// time: accept (state RAM read), update and write-back, then both ratios are
// divided in parallel, one quotient bit per cycle. A divider whose ratio is
// forced to zero or saturated finishes after its prepare step, with no bit
// steps. The next packet can be accepted in the cycle after the result is
// loaded.
// A finished result waits in the output register while the next packet is
// accepted. Per-direction state lives in a 2-entry RAM whose entries read as
// zero until first written. half_period_length sits at APB address 0.
// Uses sqlb_pkg, sqlb_ram and sqlb_div.
module square_retransmit_bit_loss_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sqlb_pkg::PADDR_W-1:0]   paddr,
	input  logic [sqlb_pkg::PDATA_W-1:0]   pwdata,
	output logic [sqlb_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	input  logic                           pkt_valid,
	output logic                           pkt_stall,
	input  sqlb_pkg::pkt_t                 pkt,
	output logic                           meas_valid,
	input  logic                           meas_stall,
	output sqlb_pkg::meas_t                meas
);
	import sqlb_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV
	} state_t;

	state_t             state_q;
	logic [15:0]        hpl_q;
	logic [NUM_DIR-1:0] vld_q;
	pkt_t               pkt_q;
	logic               out_vld_q;
	meas_t              out_q;
	logic [31:0]        sq_tot_q;
	logic [31:0]        lb_tot_q;
	logic               flip_q;
	logic               zero_q;

	logic               pkt_acc;
	logic               cfg_wr;
	logic [$bits(dir_state_t)-1:0] ram_rdata;
	logic               ram_we;
	dir_state_t         cur;
	dir_state_t         nxt;
	logic               first;
	logic               flip;
	logic               cnt_zero;
	div_req_t           sq_req;
	div_req_t           lb_req;
	logic               sq_busy;
	logic               lb_busy;
	logic [RATIO_W-1:0] sq_ratio;
	logic [RATIO_W-1:0] lb_ratio;
	logic               div_done;
	logic               out_load;

	// APB register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_HALF_PERIOD);
	assign prdata = (paddr[2] == REG_HALF_PERIOD) ? PDATA_W'(hpl_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpl_q <= HALF_PERIOD_RESET;
		end else if (cfg_wr) begin
			hpl_q <= pwdata[15:0];
		end
	end

	// Handshakes
	assign pkt_stall  = (state_q != ST_IDLE);
	assign pkt_acc    = pkt_valid && !pkt_stall;
	assign div_done   = (state_q == ST_DIV) && !sq_busy && !lb_busy;
	assign out_load   = div_done && (!out_vld_q || !meas_stall);
	assign meas_valid = out_vld_q;
	assign meas       = out_q;

	// State RAM: read at accept, written back in the update cycle
	assign ram_we = (state_q == ST_UPD);

	sqlb_ram #(
		.WIDTH ($bits(dir_state_t)),
		.DEPTH (NUM_DIR)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pkt_q.direction),
		.wdata (nxt),
		.re    (pkt_acc),
		.raddr (pkt.direction),
		.rdata (ram_rdata)
	);

	// Never-written entries read as zero
	assign cur = vld_q[pkt_q.direction] ? dir_state_t'(ram_rdata) : '0;

	// Square-bit run tracking and loss accumulation
	always_comb begin
		first = (cur.run_length == '0) && (cur.half_period_rank == '0);
		flip  = !first && (pkt_q.q_bit != cur.current_square);
		nxt   = cur;
		if (first || flip) begin
			nxt.current_square = pkt_q.q_bit;
			nxt.run_length     = 16'd1;
		end else if (cur.run_length != 16'hFFFF) begin
			nxt.run_length = cur.run_length + 16'd1;
		end
		if (flip) begin
			nxt.upstream_loss    = cur.upstream_loss + 32'(hpl_q) - 32'(cur.run_length);
			nxt.half_period_rank = cur.half_period_rank + 32'd1;
		end
		nxt.loss_bit_count = cur.loss_bit_count + 32'(pkt_q.l_bit);
	end

	assign cnt_zero = (pkt_q.packets_seen == '0);

	// Divider requests, issued in the update cycle
	always_comb begin
		sq_req.start      = ram_we;
		sq_req.force_zero = cnt_zero || nxt.upstream_loss[31];
		sq_req.total      = nxt.upstream_loss;
		sq_req.count      = pkt_q.packets_seen;
		lb_req.start      = ram_we;
		lb_req.force_zero = cnt_zero;
		lb_req.total      = nxt.loss_bit_count;
		lb_req.count      = pkt_q.packets_seen;
	end

	sqlb_div u_sq_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.busy   (sq_busy),
		.ratio  (sq_ratio)
	);

	sqlb_div u_lb_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lb_req),
		.busy   (lb_busy),
		.ratio  (lb_ratio)
	);

	// Sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
			vld_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pkt_acc) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					vld_q[pkt_q.direction] <= 1'b1;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!meas_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (pkt_acc) begin
			pkt_q <= pkt;
		end
		if (ram_we) begin
			sq_tot_q <= nxt.upstream_loss;
			lb_tot_q <= nxt.loss_bit_count;
			flip_q   <= flip;
			zero_q   <= cnt_zero;
		end
		if (out_load) begin
			out_q.square_loss_total <= sq_tot_q;
			out_q.loss_bit_total    <= lb_tot_q;
			out_q.square_loss_ratio <= sq_ratio;
			out_q.loss_bit_ratio    <= lb_ratio;
			out_q.half_period_ended <= flip_q;
			out_q.zero_packet_count <= zero_q;
		end
	end

	// Checks
	a_write_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_acc |=> ram_we)
		else $error("state write-back did not follow packet accept");

	a_result_after_divide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_DIV))
		else $error("result raised outside divide completion");

	a_zero_count_ratios: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && meas.zero_packet_count |->
		(meas.square_loss_ratio == '0) && (meas.loss_bit_ratio == '0))
		else $error("nonzero ratio with zero packet count");

	a_negative_loss_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && meas.square_loss_total[31] |-> (meas.square_loss_ratio == '0))
		else $error("nonzero ratio for negative upstream loss");

endmodule

/* verif/tb.sv */
// Testbench for the square/loss bit loss tracker: APB register access, directed packets,
// random packet traffic under idling on both sides, long-run and large-loss stress.
// Depends on rtl/sqlb_pkg.sv and the top level square_retransmit_bit_loss_tracker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sqlb_pkg::*;

	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 7;
	localparam longint CYCLE_LIMIT = 12_000_000;
	localparam int MAX_REPORTS = 10;
	localparam logic [PADDR_W-1:0] ADDR_HALF_PERIOD = {REG_HALF_PERIOD, 2'b00};
	localparam logic [23:0] RATIO_SAT = 24'hFF_FFFF;

	// DUT connections, all inputs known from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic pkt_valid = 1'b0;
	logic pkt_stall;
	pkt_t pkt = '0;
	logic meas_valid;
	logic meas_stall = 1'b0;
	meas_t meas;

	// Idle rates in percent
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	// Predicted tracker state
	logic [15:0] half_period;
	logic        cur_square [2];
	logic [15:0] run_len [2];
	logic [31:0] hp_rank [2];
	logic [31:0] up_loss [2];
	logic [31:0] lb_count [2];

	meas_t meas_expected [$];
	int mismatches = 0;
	longint cycle_count = 0;

	// Random traffic shaping: planned square runs and per-side packet counters
	int          run_left [2];
	logic        plan_q [2];
	logic [31:0] side_seen [2];

	square_retransmit_bit_loss_tracker u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.pkt_valid(pkt_valid),
		.pkt_stall(pkt_stall),
		.pkt(pkt),
		.meas_valid(meas_valid),
		.meas_stall(meas_stall),
		.meas(meas)
	);

	always #(CLK_HALF) clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				meas_expected.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver back-pressure
	always @(negedge clk) begin
		meas_stall <= ($urandom_range(0, 99) < rx_idle_pct);
	end

	// Q8.16 ratio, truncated, saturated, zero for a zero count
	function automatic logic [23:0] q816_ratio(logic [31:0] total, logic [31:0] cnt);
		logic [63:0] q;
		if (cnt == 32'd0)
			return 24'd0;
		q = ({32'd0, total} << RATIO_FRAC_BITS) / {32'd0, cnt};
		if (q > {40'd0, RATIO_SAT})
			return RATIO_SAT;
		return q[23:0];
	endfunction

	// Advance the predicted state by one packet and return its measurement
	function automatic meas_t track_packet(pkt_t p);
		meas_t m;
		logic d;
		logic flip;
		logic [31:0] up;
		d = p.direction;
		flip = 1'b0;
		if (run_len[d] == 16'd0 && hp_rank[d] == 32'd0) begin
			cur_square[d] = p.q_bit;
			run_len[d] = 16'd1;
		end else if (p.q_bit == cur_square[d]) begin
			if (run_len[d] != 16'hFFFF)
				run_len[d] = run_len[d] + 16'd1;
		end else begin
			up_loss[d] = up_loss[d] + ({16'd0, half_period} - {16'd0, run_len[d]});
			cur_square[d] = p.q_bit;
			run_len[d] = 16'd1;
			hp_rank[d] = hp_rank[d] + 32'd1;
			flip = 1'b1;
		end
		lb_count[d] = lb_count[d] + {31'd0, p.l_bit};
		up = up_loss[d];
		m.square_loss_total = up;
		m.loss_bit_total = lb_count[d];
		m.square_loss_ratio = up[31] ? 24'd0 : q816_ratio(up, p.packets_seen);
		m.loss_bit_ratio = q816_ratio(lb_count[d], p.packets_seen);
		m.half_period_ended = flip;
		m.zero_packet_count = (p.packets_seen == 32'd0);
		return m;
	endfunction

	task automatic report_mismatch(string what, meas_t exp_m, meas_t act_m);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t: %s", $realtime, what);
			$display("  exp: sq_tot=%0d lb_tot=%0d sq_ratio=%h lb_ratio=%h hp_end=%b zero=%b",
				exp_m.square_loss_total, exp_m.loss_bit_total, exp_m.square_loss_ratio,
				exp_m.loss_bit_ratio, exp_m.half_period_ended, exp_m.zero_packet_count);
			$display("  act: sq_tot=%0d lb_tot=%0d sq_ratio=%h lb_ratio=%h hp_end=%b zero=%b",
				act_m.square_loss_total, act_m.loss_bit_total, act_m.square_loss_ratio,
				act_m.loss_bit_ratio, act_m.half_period_ended, act_m.zero_packet_count);
		end
	endtask

	// Result checker: every accepted measurement against the oldest prediction
	always @(posedge clk) begin
		meas_t exp_m;
		if (arst_n && meas_valid && !meas_stall) begin
			if (meas_expected.size() == 0) begin
				report_mismatch("measurement with no packet pending", '0, meas);
			end else begin
				exp_m = meas_expected.pop_front();
				if (meas.square_loss_total !== exp_m.square_loss_total ||
						meas.loss_bit_total !== exp_m.loss_bit_total ||
						meas.square_loss_ratio !== exp_m.square_loss_ratio ||
						meas.loss_bit_ratio !== exp_m.loss_bit_ratio ||
						meas.half_period_ended !== exp_m.half_period_ended ||
						meas.zero_packet_count !== exp_m.zero_packet_count)
					report_mismatch("measurement mismatch", exp_m, meas);
			end
		end
	end

	// Send one packet transaction; prediction taken at the accepting edge
	task automatic send_packet(pkt_t p);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			pkt_valid <= 1'b0;
			@(negedge clk);
		end
		pkt <= p;
		pkt_valid <= 1'b1;
		do @(posedge clk); while (pkt_stall);
		meas_expected.push_back(track_packet(p));
	endtask

	task automatic send_fields(logic d, logic q, logic l, logic [31:0] cnt);
		pkt_t p;
		p.direction = d;
		p.q_bit = q;
		p.l_bit = l;
		p.packets_seen = cnt;
		send_packet(p);
	endtask

	// Hold the sender off until every predicted measurement has arrived
	task automatic drain_measurements();
		@(negedge clk);
		pkt_valid <= 1'b0;
		while (meas_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_HALF_PERIOD)
			half_period = data[15:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read(logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write half_period_length while idle and read it back
	task automatic set_half_period(logic [15:0] value);
		logic [PDATA_W-1:0] rd;
		drain_measurements();
		// upper bits carry junk; only 16 bits are kept
		apb_write(ADDR_HALF_PERIOD, {16'($urandom()), value});
		apb_read(ADDR_HALF_PERIOD, rd);
		if (rd !== {16'd0, half_period}) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: half_period readback exp %h act %h", $realtime,
					{16'd0, half_period}, rd);
		end
	endtask

	task automatic test_register_access();
		logic [PDATA_W-1:0] rd;
		apb_read(ADDR_HALF_PERIOD, rd);
		if (rd !== {16'd0, HALF_PERIOD_RESET}) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: half_period reset value exp %h act %h", $realtime,
					{16'd0, HALF_PERIOD_RESET}, rd);
		end
		set_half_period(16'hFFFF);
		set_half_period(16'h0000);
		set_half_period(HALF_PERIOD_RESET);
	endtask

	task automatic test_directed_cases();
		// first packet latches the square bit, one loss bit over one packet
		send_fields(1'b0, 1'b1, 1'b1, 32'd1);
		// same square, zero packet count forces ratios to zero
		send_fields(1'b0, 1'b1, 1'b0, 32'd0);
		// flip: 64 - 2 added
		send_fields(1'b0, 1'b0, 1'b1, 32'd2);
		// other direction: first packet with maximal count
		send_fields(1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF);
		send_fields(1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF);
		send_fields(1'b1, 1'b1, 1'b1, 32'h8000_0000);
		// minimum half period: a longer run subtracts from the loss
		set_half_period(16'd1);
		send_fields(1'b1, 1'b1, 1'b0, 32'd7);
		send_fields(1'b1, 1'b1, 1'b1, 32'd9);
		send_fields(1'b1, 1'b0, 1'b0, 32'd10);
		send_fields(1'b1, 1'b1, 1'b1, 32'd3);
		// zero half period: a flip subtracts the run length
		set_half_period(16'd0);
		send_fields(1'b0, 1'b0, 1'b0, 32'd100);
		send_fields(1'b0, 1'b0, 1'b1, 32'd101);
		send_fields(1'b0, 1'b1, 1'b0, 32'd102);
		send_fields(1'b0, 1'b0, 1'b0, 32'd0);
		// maximal half period with a tiny count: saturated ratio
		set_half_period(16'hFFFF);
		send_fields(1'b0, 1'b1, 1'b1, 32'd1);
		send_fields(1'b0, 1'b0, 1'b1, 32'd1);
		send_fields(1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);
		send_fields(1'b1, 1'b0, 1'b1, 32'd1);
		send_fields(1'b1, 1'b1, 1'b1, 32'h0001_0000);
		set_half_period(HALF_PERIOD_RESET);
	endtask

	function automatic int next_run_length();
		int len;
		if (half_period <= 16'd80) begin
			len = int'(half_period) + $urandom_range(0, 4) - 2;
			if (len < 1)
				len = 1;
		end else begin
			len = $urandom_range(1, 12);
		end
		return len;
	endfunction

	// Mostly well-formed square runs per direction, with some noise packets
	function automatic pkt_t random_packet();
		pkt_t p;
		logic d;
		int pick;
		d = 1'($urandom_range(0, 1));
		p.direction = d;
		if ($urandom_range(0, 99) < 10) begin
			p.q_bit = 1'($urandom_range(0, 1));
		end else begin
			p.q_bit = plan_q[d];
			run_left[d]--;
			if (run_left[d] <= 0) begin
				plan_q[d] = ~plan_q[d];
				run_left[d] = next_run_length();
			end
		end
		p.l_bit = ($urandom_range(0, 99) < 30);
		side_seen[d] = side_seen[d] + 32'd1;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			p.packets_seen = side_seen[d];
		else if (pick < 80)
			p.packets_seen = 32'd0;
		else if (pick < 90)
			p.packets_seen = $urandom();
		else
			p.packets_seen = $urandom_range(1, 4);
		return p;
	endfunction

	task automatic random_batch(int n_items);
		for (int i = 0; i < n_items; i++)
			send_packet(random_packet());
	endtask

	task automatic test_random_traffic(int tx_pct, int rx_pct);
		logic [15:0] settings [6];
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		settings[0] = HALF_PERIOD_RESET;
		settings[1] = 16'd1;
		settings[2] = 16'd0;
		settings[3] = 16'hFFFF;
		settings[4] = 16'd5;
		settings[5] = 16'($urandom_range(2, 80));
		for (int s = 0; s < 6; s++) begin
			set_half_period(settings[s]);
			for (int d = 0; d < 2; d++)
				run_left[d] = next_run_length();
			random_batch(34);
			// sender holds off until the pipeline is empty
			drain_measurements();
			random_batch(32);
		end
	endtask

	// A long run, then a flip with a zero half period
	task automatic test_long_run();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_half_period(16'd0);
		for (int i = 0; i < 150; i++)
			send_fields(1'b0, cur_square[0], 1'($urandom_range(0, 1)), 32'd0);
		send_fields(1'b0, ~cur_square[0], 1'b1, 32'd5);
		send_fields(1'b0, cur_square[0], 1'b0, 32'd1);
	endtask

	// Flip on every packet with the largest half period: large loss, saturated square ratio at count one
	task automatic test_large_loss();
		set_half_period(16'hFFFF);
		for (int i = 0; i < 59; i++)
			send_fields(1'b1, ~cur_square[1], 1'b0, (i % 16 == 0) ? 32'd1 : 32'($urandom()));
		send_fields(1'b1, ~cur_square[1], 1'b1, 32'd1);
	endtask

	initial begin
		half_period = HALF_PERIOD_RESET;
		for (int d = 0; d < 2; d++) begin
			cur_square[d] = 1'b0;
			run_len[d] = 16'd0;
			hp_rank[d] = 32'd0;
			up_loss[d] = 32'd0;
			lb_count[d] = 32'd0;
			run_left[d] = 1;
			plan_q[d] = 1'($urandom_range(0, 1));
			side_seen[d] = 32'd0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_register_access();
		tx_idle_pct = 15;
		rx_idle_pct = 75;
		test_directed_cases();
		test_random_traffic(15, 75);
		test_random_traffic(75, 15);
		test_random_traffic(0, 0);
		test_long_run();
		test_large_loss();

		drain_measurements();
		repeat (60) @(posedge clk);
		if (mismatches == 0 && meas_expected.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
